// ===== rtl/capture_compare_timer_unit_defines.svh =====
// Assertion macros shared by the timer checker.
// Included by the checker file; no other dependencies.
`ifndef CAPTURE_COMPARE_TIMER_UNIT_DEFINES_SVH
`define CAPTURE_COMPARE_TIMER_UNIT_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define CCT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define CCT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/cct_pkg.sv =====
// Shared types and constants of the capture/compare timer.
// No dependencies; used by the core, the top level and the checker.
package cct_pkg;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_PIN   = 2'd1,
      OP_READ  = 2'd2,
      OP_WRITE = 2'd3
   } op_type;

   localparam logic [3:0] SEL_STATUS   = 4'd0;
   localparam logic [3:0] SEL_CAP_HI   = 4'd1;
   localparam logic [3:0] SEL_CAP_LO   = 4'd2;
   localparam logic [3:0] SEL_CMP_HI   = 4'd3;
   localparam logic [3:0] SEL_CMP_LO   = 4'd4;
   localparam logic [3:0] SEL_CNT_HI   = 4'd5;
   localparam logic [3:0] SEL_CNT_LO   = 4'd6;
   localparam logic [3:0] SEL_ALT_HI   = 4'd7;
   localparam logic [3:0] SEL_ALT_LO   = 4'd8;
   localparam logic [3:0] SEL_CONTROL  = 4'd9;

   localparam int FLAG_OVF = 0;
   localparam int FLAG_CMP = 1;
   localparam int FLAG_CAP = 2;

   localparam int CTL_CAP_IE  = 7;
   localparam int CTL_CMP_IE  = 6;
   localparam int CTL_OVF_IE  = 5;
   localparam int CTL_RISING  = 1;
   localparam int CTL_CMP_LVL = 0;

   localparam logic [15:0] COUNT_RESET = 16'hFFFB;
   localparam logic [15:0] COUNT_MAX   = 16'hFFFF;

   typedef struct packed {
      op_type     op;
      logic [3:0] sel;
      logic [7:0] wdata;
      logic       pin;
      logic       masked;
   } item_type;

   typedef struct packed {
      logic       cmp_pin;
      logic       cmp_event;
      logic       irq;
      logic [7:0] rdata;
   } result_type;

endpackage

// ===== rtl/cct_core.sv =====
// Timer state and per-beat update: counter, capture, compare, flags, latches.
// Depends on cct_pkg; instantiated by capture_compare_timer_unit.
module cct_core
   import cct_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       item_valid,
   input  item_type   item,
   input  logic       cfg_we,
   input  logic [7:0] cfg_data,
   output result_type result
);

   logic [7:0]  control_ff,   control_in;
   logic [15:0] count_ff,     count_in;
   logic [15:0] capture_ff,   capture_in;
   logic [15:0] compare_ff,   compare_in;
   logic [2:0]  flags_ff,     flags_in;
   logic [2:0]  armed_ff,     armed_in;
   logic        inhibit_ff,   inhibit_in;
   logic [7:0]  latch_ff [2];
   logic [7:0]  latch_in [2];
   logic [1:0]  latch_vld_ff, latch_vld_in;
   logic        last_pin_ff,  last_pin_in;
   logic        pin_out_ff,   pin_out_in;

   logic [15:0] count_inc;
   logic        edge_hit;

   always_comb begin
      control_in   = control_ff;
      count_in     = count_ff;
      capture_in   = capture_ff;
      compare_in   = compare_ff;
      flags_in     = flags_ff;
      armed_in     = armed_ff;
      inhibit_in   = inhibit_ff;
      latch_in[0]  = latch_ff[0];
      latch_in[1]  = latch_ff[1];
      latch_vld_in = latch_vld_ff;
      last_pin_in  = last_pin_ff;
      pin_out_in   = pin_out_ff;
      result       = '0;
      count_inc    = count_ff + 16'd1;
      edge_hit     = control_ff[CTL_RISING] ? (!last_pin_ff && item.pin)
                                            : (last_pin_ff && !item.pin);

      if (item_valid) begin
         case (item.op)
            OP_TICK: begin
               count_in = count_inc;
               if (count_ff == COUNT_MAX) begin
                  flags_in[FLAG_OVF] = 1'b1;
                  if (control_ff[CTL_OVF_IE] && !item.masked) result.irq = 1'b1;
               end
               if (!inhibit_ff && count_inc == compare_ff) begin
                  result.cmp_event   = 1'b1;
                  flags_in[FLAG_CMP] = 1'b1;
                  if (control_ff[CTL_CMP_IE] && !item.masked) result.irq = 1'b1;
                  pin_out_in = control_ff[CTL_CMP_LVL];
               end
            end
            OP_PIN: begin
               if (edge_hit) begin
                  capture_in         = count_ff;
                  flags_in[FLAG_CAP] = 1'b1;
                  if (control_ff[CTL_CAP_IE] && !item.masked) result.irq = 1'b1;
               end
               last_pin_in = item.pin;
            end
            OP_READ: begin
               case (item.sel)
                  SEL_STATUS: begin
                     armed_in     = armed_ff | flags_ff;
                     result.rdata = {flags_ff, 5'b0};
                  end
                  SEL_CAP_HI: result.rdata = capture_ff[15:8];
                  SEL_CAP_LO: begin
                     if (armed_ff[FLAG_CAP]) begin
                        flags_in[FLAG_CAP] = 1'b0;
                        armed_in[FLAG_CAP] = 1'b0;
                     end
                     result.rdata = capture_ff[7:0];
                  end
                  SEL_CMP_HI: begin
                     inhibit_in   = 1'b1;
                     result.rdata = compare_ff[15:8];
                  end
                  SEL_CMP_LO: begin
                     if (armed_ff[FLAG_CMP]) begin
                        flags_in[FLAG_CMP] = 1'b0;
                        armed_in[FLAG_CMP] = 1'b0;
                     end
                     inhibit_in   = 1'b0;
                     result.rdata = compare_ff[7:0];
                  end
                  SEL_CNT_HI: begin
                     if (!latch_vld_ff[0]) begin
                        latch_in[0]     = count_ff[7:0];
                        latch_vld_in[0] = 1'b1;
                     end
                     result.rdata = count_ff[15:8];
                  end
                  SEL_CNT_LO: begin
                     if (armed_ff[FLAG_OVF]) begin
                        flags_in[FLAG_OVF] = 1'b0;
                        armed_in[FLAG_OVF] = 1'b0;
                     end
                     latch_vld_in[0] = 1'b0;
                     result.rdata = latch_vld_ff[0] ? latch_ff[0] : count_ff[7:0];
                  end
                  SEL_ALT_HI: begin
                     if (!latch_vld_ff[1]) begin
                        latch_in[1]     = count_ff[7:0];
                        latch_vld_in[1] = 1'b1;
                     end
                     result.rdata = count_ff[15:8];
                  end
                  SEL_ALT_LO: begin
                     latch_vld_in[1] = 1'b0;
                     result.rdata = latch_vld_ff[1] ? latch_ff[1] : count_ff[7:0];
                  end
                  SEL_CONTROL: result.rdata = control_ff;
                  default:     result.rdata = 8'd0;
               endcase
            end
            default: begin
               case (item.sel)
                  SEL_CMP_HI:  compare_in[15:8] = item.wdata;
                  SEL_CMP_LO:  compare_in[7:0]  = item.wdata;
                  SEL_CONTROL: control_in       = item.wdata;
                  default:     ;
               endcase
            end
         endcase
      end

      if (cfg_we) control_in = cfg_data;
      result.cmp_pin = pin_out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         control_ff   <= 8'd0;
         count_ff     <= COUNT_RESET;
         capture_ff   <= 16'd0;
         compare_ff   <= 16'd0;
         flags_ff     <= 3'd0;
         armed_ff     <= 3'd0;
         inhibit_ff   <= 1'b0;
         latch_ff[0]  <= 8'd0;
         latch_ff[1]  <= 8'd0;
         latch_vld_ff <= 2'd0;
         last_pin_ff  <= 1'b0;
         pin_out_ff   <= 1'b0;
      end else begin
         control_ff   <= control_in;
         count_ff     <= count_in;
         capture_ff   <= capture_in;
         compare_ff   <= compare_in;
         flags_ff     <= flags_in;
         armed_ff     <= armed_in;
         inhibit_ff   <= inhibit_in;
         latch_ff[0]  <= latch_in[0];
         latch_ff[1]  <= latch_in[1];
         latch_vld_ff <= latch_vld_in;
         last_pin_ff  <= last_pin_in;
         pin_out_ff   <= pin_out_in;
      end
   end

endmodule

// ===== rtl/capture_compare_timer_unit.sv =====
// Top level of the 16-bit capture/compare timer: beat handshake and result register.
// Depends on cct_pkg and cct_core.
//
// One request beat (tick, capture pin level, register read or write) yields one
// response beat. Every beat is processed combinationally by cct_core and its
// result lands in a one-entry output register, so the block takes one beat per
// clock as long as the response side drains; req_tready drops only while a
// response is held. The response appears in the cycle after the request is
// accepted. The control register is written through the csr channel (always
// ready) or by a write beat to select 9.
module capture_compare_timer_unit
   import cct_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // write_data[7:0], pin_level[8], cpu_irq_masked[9]
   input  logic [5:0]  req_tuser,   // op[1:0], reg_select[5:2]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // read_data[7:0], irq_request[8], compare_event[9],
                                    // compare_pin[10]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   item_type   item;
   result_type result;
   logic       accept;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign item.op     = op_type'(req_tuser[1:0]);
   assign item.sel    = req_tuser[5:2];
   assign item.wdata  = req_tdata[7:0];
   assign item.pin    = req_tdata[8];
   assign item.masked = req_tdata[9];

   cct_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (accept),
      .item       (item),
      .cfg_we     (csr_valid && csr_ready),
      .cfg_data   (csr_data),
      .result     (result)
   );

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_data_ff};

endmodule

// ===== rtl/cct_checker.sv =====
// Port-level checks for capture_compare_timer_unit, attached by bind.
// Depends on cct_pkg and capture_compare_timer_unit_defines.svh.
`include "capture_compare_timer_unit_defines.svh"

module cct_checker
   import cct_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [5:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   logic req_beat;
   logic bus_op;

   assign req_beat = req_tvalid && req_tready;
   assign bus_op   = (req_tuser[1:0] == OP_READ) || (req_tuser[1:0] == OP_WRITE);

   `CCT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "response changed while stalled")

   `CCT_ASSERT_NEXT(a_req_to_rsp, clock, reset, req_beat, rsp_tvalid, "request beat gave no response")

   `CCT_ASSERT_NEXT(a_bus_no_event, clock, reset, req_beat && bus_op, rsp_tdata[9:8] == 2'b00, "bus access raised irq or compare event")

   `CCT_ASSERT_NEXT(a_nonread_zero, clock, reset, req_beat && req_tuser[1:0] != OP_READ, rsp_tdata[7:0] == 8'd0, "read data nonzero for non-read beat")

   `CCT_ASSERT_SAME(a_pad_zero, clock, reset, rsp_tvalid, rsp_tdata[15:11] == 5'd0, "response padding bits set")

endmodule

bind capture_compare_timer_unit cct_checker u_cct_checker (.*);
